@@ design/voxel_ray_traversal_unit_defines.svh @@
// assertion macros used by the checker file
`ifndef VOXEL_RAY_TRAVERSAL_UNIT_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_UNIT_DEFINES_SVH

// property checked outside reset
`define VRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define VRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/vrt_pkg.sv @@
`default_nettype none
package vrt_pkg;

  // port widths
  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  // input kinds
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_ANSWER = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_PROBE = 2'd0;
  localparam logic [1:0] STATUS_HIT   = 2'd1;
  localparam logic [1:0] STATUS_MISS  = 2'd2;
  localparam logic [1:0] STATUS_OOR   = 2'd3;

  // face codes
  localparam logic [2:0] FACE_NONE = 3'd0;

  // per-axis step sign
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  localparam logic [31:0] T_MAX = 32'hFFFF_FFFF;

  // divider jobs: three boundary distances, three cell steps, then range
  localparam logic [2:0] JOB_REACH = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_START_OUT,
    ST_STEP
  } state_t;

endpackage
`default_nettype wire

@@ design/voxel_ray_traversal_unit.sv @@
// ray start: accept, sum of squares, 16-bit root, seven divides (skipped on zero
//   divisors) and output, all by one shared bit-serial divider and root unit
// answer (ray active): one compare, add and select step, then the registered result
// one transaction in flight; no input taken while a result waits on the output,
//   nor while a ray start or an answer is being worked
// synchronous active-high reset: no ray in progress, output empty
`default_nettype none
module voxel_ray_traversal_unit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, range, solid
  input  logic [vrt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // action
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // voxel_x, voxel_y, voxel_z, face
  output logic [vrt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status
  output logic [vrt_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  localparam int CB       = COORD_BITS;
  localparam int SW       = 32 - FRAC_BITS;
  localparam int NC_SHIFT = 31 - FRAC_BITS;
  localparam logic signed [63:0] C_LO = -(64'sd1 <<< (COORD_BITS - 1));
  localparam logic signed [63:0] C_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;

  function automatic logic in_rng(input logic signed [63:0] v);
    in_rng = (v >= C_LO) && (v <= C_HI);
  endfunction

  vrt_pkg::state_t state, state_next;

  // latched input
  logic signed [31:0] origin [3];
  logic signed [15:0] dir [3];
  logic [23:0]        max_dist;
  logic               solid_r;

  // sequencing
  logic [1:0] idx;
  logic [2:0] job;
  logic [5:0] cnt;

  // shared squaring, root and divide unit
  logic [31:0] sq;
  logic [17:0] sqr_rem;
  logic [15:0] root;
  logic [47:0] num;
  logic [47:0] quot;
  logic [15:0] rem;
  logic [15:0] divisor;

  // ray state
  logic signed [CB-1:0] cell_pos [3];
  logic [31:0]          next_cross [3];
  logic [31:0]          cross_step [3];
  logic [1:0]           axis_sign [3];
  logic [31:0]          reach;
  logic [2:0]           entry_face;
  logic                 ray_active;

  // output register
  logic [1:0]  out_status;
  logic [15:0] out_vox [3];
  logic [2:0]  out_face;

  logic accept;
  logic do_load;

  // unpacked views
  logic [15:0]          ad [3];
  logic signed [SW-1:0] start_cell [3];
  logic                 start_ok;

  // divider job decode
  logic [15:0] job_div;
  logic [47:0] job_num;
  logic [1:0]  job_axis;
  logic [FRAC_BITS:0] bnd_dist;
  logic               div_zero;

  // divider step
  logic [16:0] rem_sh;
  logic        ge;
  logic [47:0] q_fin;

  // root step
  logic [19:0] rt_sh;
  logic [19:0] rt_trial;
  logic        rt_ge;

  // traversal step
  logic [32:0]        key [3];
  logic [1:0]         c;
  logic               miss;
  logic [2:0]         face;
  logic signed [CB:0] cur;
  logic signed [CB:0] moved;
  logic               moved_ok;

  assign accept = s_axis_tvalid && s_axis_tready;

  // per-axis views of the latched ray
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ad[a]         = dir[a][15] ? 16'(-dir[a]) : 16'(dir[a]);
      start_cell[a] = origin[a][31:FRAC_BITS];
    end
    start_ok = in_rng(64'(start_cell[0])) && in_rng(64'(start_cell[1]))
               && in_rng(64'(start_cell[2]));
  end

  // divider job operands
  always_comb begin
    job_axis = 2'd0;
    job_div  = root;
    job_num  = {1'b0, max_dist, 23'b0};
    case (job)
      3'd0, 3'd1, 3'd2: job_axis = job[1:0];
      3'd3:             job_axis = 2'd0;
      3'd4:             job_axis = 2'd1;
      3'd5:             job_axis = 2'd2;
      default:          job_axis = 2'd0;
    endcase
    bnd_dist = (dir[job_axis] > 0)
               ? ((FRAC_BITS+1)'(1) << FRAC_BITS)
                 - (FRAC_BITS+1)'(origin[job_axis][FRAC_BITS-1:0])
               : (FRAC_BITS+1)'(origin[job_axis][FRAC_BITS-1:0]);
    if (job < 3'd3) begin
      job_div = ad[job_axis];
      job_num = 48'((32'(bnd_dist)) << NC_SHIFT);
    end else if (job != vrt_pkg::JOB_REACH) begin
      job_div = ad[job_axis];
      job_num = 48'h0000_8000_0000;
    end
    div_zero = (job_div == 16'd0);
  end

  // restoring divide step, one quotient bit
  always_comb begin
    rem_sh = {rem, num[47]};
    ge     = rem_sh >= {1'b0, divisor};
    q_fin  = {quot[46:0], ge};
  end

  // square root step, one root bit
  always_comb begin
    rt_sh    = {sqr_rem, sq[31:30]};
    rt_trial = {2'b00, root, 2'b01};
    rt_ge    = rt_sh >= rt_trial;
  end

  // axis choice and step
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      key[a] = (axis_sign[a] != vrt_pkg::SIGN_ZERO) ? {1'b0, next_cross[a]}
                                                    : 33'h1_0000_0000;
    end
    if (key[0] < key[1]) c = (key[0] < key[2]) ? 2'd0 : 2'd2;
    else                 c = (key[1] < key[2]) ? 2'd1 : 2'd2;
    miss = (axis_sign[c] == vrt_pkg::SIGN_ZERO) || (next_cross[c] > reach);
    face = {c, 1'b0} + ((axis_sign[c] == vrt_pkg::SIGN_POS) ? 3'd1 : 3'd2);
    cur  = (CB+1)'(cell_pos[c]);
    moved = (axis_sign[c] == vrt_pkg::SIGN_POS) ? cur + 2'sd1 : cur - 2'sd1;
    moved_ok = in_rng(64'(moved));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      vrt_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser[0] == vrt_pkg::ACT_START) state_next = vrt_pkg::ST_SQ;
          else if (ray_active)                       state_next = vrt_pkg::ST_STEP;
        end
      end
      vrt_pkg::ST_SQ: begin
        if (idx == 2'd2) state_next = vrt_pkg::ST_SQRT;
      end
      vrt_pkg::ST_SQRT: begin
        if (cnt == 6'd0) state_next = vrt_pkg::ST_DIV_LOAD;
      end
      vrt_pkg::ST_DIV_LOAD: begin
        if (!div_zero)                          state_next = vrt_pkg::ST_DIV_RUN;
        else if (job == vrt_pkg::JOB_REACH)     state_next = vrt_pkg::ST_START_OUT;
      end
      vrt_pkg::ST_DIV_RUN: begin
        if (cnt == 6'd0) begin
          state_next = (job == vrt_pkg::JOB_REACH) ? vrt_pkg::ST_START_OUT
                                                   : vrt_pkg::ST_DIV_LOAD;
        end
      end
      vrt_pkg::ST_START_OUT: state_next = vrt_pkg::ST_IDLE;
      vrt_pkg::ST_STEP:      state_next = vrt_pkg::ST_IDLE;
      default:               state_next = vrt_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (state == vrt_pkg::ST_IDLE) && !m_axis_tvalid;
    do_load       = (state == vrt_pkg::ST_DIV_LOAD);
    m_axis_tuser  = out_status;
    m_axis_tdata  = {5'b0, out_face, out_vox[2], out_vox[1], out_vox[0]};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= vrt_pkg::ST_IDLE;
      ray_active    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      idx           <= 2'd0;
      job           <= 3'd0;
      cnt           <= 6'd0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        vrt_pkg::ST_IDLE: begin
          idx <= 2'd0;
        end
        vrt_pkg::ST_SQ: begin
          idx <= idx + 2'd1;
          cnt <= 6'd15;
        end
        vrt_pkg::ST_SQRT: begin
          cnt <= cnt - 6'd1;
          job <= 3'd0;
        end
        vrt_pkg::ST_DIV_LOAD: begin
          cnt <= 6'd47;
          if (div_zero) job <= job + 3'd1;
        end
        vrt_pkg::ST_DIV_RUN: begin
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) job <= job + 3'd1;
        end
        vrt_pkg::ST_START_OUT: begin
          ray_active    <= start_ok;
          m_axis_tvalid <= 1'b1;
        end
        vrt_pkg::ST_STEP: begin
          m_axis_tvalid <= 1'b1;
          if (solid_r || miss || !moved_ok) ray_active <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // input capture
    if (accept) begin
      origin[0] <= s_axis_tdata[31:0];
      origin[1] <= s_axis_tdata[63:32];
      origin[2] <= s_axis_tdata[95:64];
      dir[0]    <= s_axis_tdata[111:96];
      dir[1]    <= s_axis_tdata[127:112];
      dir[2]    <= s_axis_tdata[143:128];
      max_dist  <= s_axis_tdata[167:144];
      solid_r   <= s_axis_tdata[168];
      sq        <= 32'd0;
      sqr_rem   <= 18'd0;
      root      <= 16'd0;
    end

    // sum of squares, one axis a cycle
    if (state == vrt_pkg::ST_SQ) sq <= sq + (ad[idx] * ad[idx]);

    // root, one bit a cycle
    if (state == vrt_pkg::ST_SQRT) begin
      sq <= {sq[29:0], 2'b00};
      if (rt_ge) begin
        sqr_rem <= 18'(rt_sh - rt_trial);
        root    <= {root[14:0], 1'b1};
      end else begin
        sqr_rem <= rt_sh[17:0];
        root    <= {root[14:0], 1'b0};
      end
    end

    // divider load, zero divisors take their fixed results
    if (do_load) begin
      num     <= job_num;
      divisor <= job_div;
      rem     <= 16'd0;
      quot    <= 48'd0;
      if (div_zero) begin
        if (job < 3'd3)                     next_cross[job_axis] <= vrt_pkg::T_MAX;
        else if (job != vrt_pkg::JOB_REACH) cross_step[job_axis] <= 32'd0;
        else                                reach <= 32'd0;
      end
    end

    // divider iteration and result write
    if (state == vrt_pkg::ST_DIV_RUN) begin
      num  <= {num[46:0], 1'b0};
      quot <= q_fin;
      rem  <= ge ? 16'(rem_sh - {1'b0, divisor}) : rem_sh[15:0];
      if (cnt == 6'd0) begin
        if (job < 3'd3)                     next_cross[job_axis] <= q_fin[31:0];
        else if (job != vrt_pkg::JOB_REACH) cross_step[job_axis] <= q_fin[31:0];
        else reach <= (q_fin[47:32] != 16'd0) ? vrt_pkg::T_MAX : q_fin[31:0];
      end
    end

    // first probe or out of range at start
    if (state == vrt_pkg::ST_START_OUT) begin
      entry_face <= vrt_pkg::FACE_NONE;
      out_face   <= vrt_pkg::FACE_NONE;
      out_status <= start_ok ? vrt_pkg::STATUS_PROBE : vrt_pkg::STATUS_OOR;
      for (int a = 0; a < 3; a++) begin
        out_vox[a]  <= 16'(start_cell[a]);
        cell_pos[a] <= CB'(start_cell[a]);
        if (dir[a] == 16'sd0)    axis_sign[a] <= vrt_pkg::SIGN_ZERO;
        else if (dir[a][15])     axis_sign[a] <= vrt_pkg::SIGN_NEG;
        else                     axis_sign[a] <= vrt_pkg::SIGN_POS;
      end
    end

    // answer: hit, miss, out of range or next probe
    if (state == vrt_pkg::ST_STEP) begin
      // stepped axis shows the moved cell, the others stay
      for (int a = 0; a < 3; a++) begin
        out_vox[a] <= (!solid_r && !miss && (a == int'(c))) ? 16'(moved)
                                                            : 16'(cell_pos[a]);
      end
      if (solid_r) begin
        out_status <= vrt_pkg::STATUS_HIT;
        out_face   <= entry_face;
      end else if (miss) begin
        out_status <= vrt_pkg::STATUS_MISS;
        out_face   <= vrt_pkg::FACE_NONE;
      end else begin
        out_face   <= face;
        if (!moved_ok) begin
          out_status <= vrt_pkg::STATUS_OOR;
        end else begin
          out_status    <= vrt_pkg::STATUS_PROBE;
          cell_pos[c]   <= CB'(moved);
          entry_face    <= face;
          next_cross[c] <= ({1'b0, next_cross[c]} + {1'b0, cross_step[c]} > 33'(vrt_pkg::T_MAX))
                           ? vrt_pkg::T_MAX : next_cross[c] + cross_step[c];
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ design/vrt_checker.sv @@
`default_nettype none
`include "voxel_ray_traversal_unit_defines.svh"
module vrt_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [vrt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input wire logic [0:0]                       s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [vrt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire logic [vrt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

  // output empty after reset
  `VRT_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_axis_tvalid, "result pending after reset")

  // no new transaction while a result waits
  `VRT_ASSERT(a_one_in_flight, (s_axis_tvalid && s_axis_tready) |-> !m_axis_tvalid, "input taken with result pending")

  // stalled result holds
  `VRT_ASSERT(a_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

  // face code always meaningful
  `VRT_ASSERT(a_face, m_axis_tvalid |-> (m_axis_tdata[50:48] != 3'd7), "bad face code")

endmodule

bind voxel_ray_traversal_unit vrt_checker u_vrt_checker (.*);
`default_nettype wire
